[hw/rtl/arithmetic_expression_tokenizer_unit_defines.svh]
// Assertion macros shared by the tokenizer RTL.
// Files that check their own logic include this header by its bare name.
// The asserting modules name their clock clk and their reset arst_n.
`ifndef ARITHMETIC_EXPRESSION_TOKENIZER_UNIT_DEFINES_SVH
`define ARITHMETIC_EXPRESSION_TOKENIZER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define AET_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

`define AET_CHECK_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define AET_CHECK(lbl, prop, msg)

`define AET_CHECK_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/aet_pkg.sv]
// Types and constants of the arithmetic expression tokenizer.
// Used by aet_scan, aet_fifo and arithmetic_expression_tokenizer_unit.
`default_nettype none

package aet_pkg;

	typedef enum logic [3:0] {
		TK_PLUS    = 4'd0,
		TK_MINUS   = 4'd1,
		TK_MUL     = 4'd2,
		TK_DIV     = 4'd3,
		TK_LPAREN  = 4'd4,
		TK_RPAREN  = 4'd5,
		TK_END     = 4'd6,
		TK_NUMBER  = 4'd7,
		TK_NAME    = 4'd8,
		TK_INVALID = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_NAME   = 2'd2,
		MODE_HALT   = 2'd3
	} mode_t;

	typedef struct packed {
		kind_t        kind;
		logic [59:0]  mantissa;
		logic [4:0]   frac;
		logic         ovf;
		logic [59:0]  letters;
		logic [3:0]   len;
		logic         last;
	} tok_t;

	// Up to two tokens written into the queue in one cycle.
	typedef struct packed {
		logic [1:0] n;
		tok_t       tok0;
		tok_t       tok1;
	} push_t;

	localparam tok_t TOK_ZERO = '0;

	localparam logic [63:0] MANT_LIMIT = 64'd999999999999999999;
	localparam logic [4:0]  FRAC_LIMIT = 5'd18;
	localparam int          NAME_SLOTS = 10;
	localparam logic [6:0]  CNT_MAX    = 7'd127;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = PTR_W + 1;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;

endpackage

`default_nettype wire

[hw/rtl/aet_fifo.sv]
// Token queue: eight entries, up to two writes and one read per cycle.
// Depends on aet_pkg for the token and push types.
`default_nettype none
`include "arithmetic_expression_tokenizer_unit_defines.svh"

module aet_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire aet_pkg::push_t   push,
	output aet_pkg::tok_t         head,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [aet_pkg::CNT_W-1:0] count
);
	import aet_pkg::*;

	tok_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_q] <= push.tok0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`AET_CHECK_ALWAYS(a_count_bound, count_q <= CNT_W'(QUEUE_DEPTH), "token queue overfilled")
	`AET_CHECK(a_double_push, (push.n == 2'd2 && !pop) |=> count_q == $past(count_q) + CNT_W'(2), "double write lost")
	`AET_CHECK(a_no_drop, $fell(out_valid) |-> $past(out_ready), "queued word vanished without a read")

endmodule

`default_nettype wire

[hw/rtl/aet_scan.sv]
// Scanner: holds the token state and turns one registered character
// into zero, one or two tokens. Depends on aet_pkg.
`default_nettype none
`include "arithmetic_expression_tokenizer_unit_defines.svh"

module aet_scan #(
	parameter int MAX_NUMBER_CHARS = 100,
	parameter int MAX_NAME_CHARS   = 10
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           valid_s1,
	input  wire logic [7:0]     char_s1,
	output aet_pkg::push_t      push
);
	import aet_pkg::*;

	mode_t        mode_q, mode_d;
	logic [59:0]  acc_q, acc_d;
	logic [4:0]   frac_q, frac_d;
	logic [1:0]   pts_q, pts_d;
	logic         sat_q, sat_d;
	logic [6:0]   cnt_q, cnt_d;
	logic [59:0]  name_q, name_d;

	logic         is_digit, is_lower, is_upper;
	logic [3:0]   digit;
	logic [63:0]  acc_x10;
	logic         fits;

	// Outcome of the character taken with no token open.
	logic         fr_emit;
	tok_t         fr_tok;
	mode_t        fr_mode;
	logic         fr_num;
	logic         fr_name;

	tok_t         num_tok, name_tok;

	assign is_digit = (char_s1 inside {[CH_0:CH_9]});
	assign is_lower = (char_s1 inside {[CH_LA:CH_LZ]});
	assign is_upper = (char_s1 inside {[CH_UA:CH_UZ]});
	assign digit    = char_s1[3:0];

	// acc * 10 + digit, checked against the eighteen-digit limit.
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {60'd0, digit};
	assign fits    = (acc_x10 <= MANT_LIMIT);

	always_comb begin
		fr_emit = 1'b0;
		fr_tok  = TOK_ZERO;
		fr_mode = MODE_IDLE;
		fr_num  = 1'b0;
		fr_name = 1'b0;
		case (char_s1)
			CH_SPACE: begin
			end
			CH_PLUS: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_PLUS;
			end
			CH_MINUS: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_MINUS;
			end
			CH_STAR: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_MUL;
			end
			CH_SLASH: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_DIV;
			end
			CH_LPAREN: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_LPAREN;
			end
			CH_RPAREN: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_RPAREN;
			end
			CH_NUL: begin
				fr_emit = 1'b1;
				fr_tok.kind = TK_END;
			end
			default: begin
				if (is_digit) begin
					fr_num = 1'b1;
					if (7'd1 >= 7'(MAX_NUMBER_CHARS)) begin
						fr_emit = 1'b1;
						fr_tok.kind = TK_NUMBER;
						fr_tok.mantissa = {56'd0, digit};
					end else begin
						fr_mode = MODE_NUMBER;
					end
				end else if (is_lower || is_upper) begin
					fr_name = 1'b1;
					if (7'd1 >= 7'(MAX_NAME_CHARS)) begin
						fr_emit = 1'b1;
						fr_tok.kind = TK_NAME;
						fr_tok.letters = {54'd0, char_s1[5:0]};
						fr_tok.len = 4'd1;
					end else begin
						fr_mode = MODE_NAME;
					end
				end else begin
					fr_emit = 1'b1;
					fr_tok.kind = TK_INVALID;
					fr_mode = MODE_HALT;
				end
			end
		endcase
	end

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		frac_d = frac_q;
		pts_d  = pts_q;
		sat_d  = sat_q;
		cnt_d  = cnt_q;
		name_d = name_q;
		push   = '0;

		if (valid_s1) begin
			case (mode_q)
				MODE_HALT: begin
				end
				MODE_NUMBER: begin
					if (is_digit || char_s1 == CH_DOT) begin
						if (char_s1 == CH_DOT) begin
							if (pts_q != 2'd2) begin
								pts_d = pts_q + 2'd1;
							end
						end else if (pts_q == 2'd0) begin
							if (!sat_q) begin
								if (fits) begin
									acc_d = acc_x10[59:0];
								end else begin
									acc_d = MANT_LIMIT[59:0];
									sat_d = 1'b1;
								end
							end
						end else if (pts_q == 2'd1) begin
							if (!sat_q && frac_q < FRAC_LIMIT && fits) begin
								acc_d  = acc_x10[59:0];
								frac_d = frac_q + 5'd1;
							end
						end
						if (cnt_q != CNT_MAX) begin
							cnt_d = cnt_q + 7'd1;
						end
						if (cnt_d >= 7'(MAX_NUMBER_CHARS)) begin
							push.n = 2'd1;
							push.tok0 = TOK_ZERO;
							push.tok0.kind = TK_NUMBER;
							push.tok0.mantissa = acc_d;
							push.tok0.frac = frac_d;
							push.tok0.ovf = sat_d;
							mode_d = MODE_IDLE;
						end
					end else begin
						push.n = fr_emit ? 2'd2 : 2'd1;
						push.tok0 = num_tok;
						push.tok1 = fr_tok;
						mode_d = fr_mode;
					end
				end
				MODE_NAME: begin
					if (is_lower && cnt_q < 7'(NAME_SLOTS)) begin
						for (int i = 0; i < NAME_SLOTS; i++) begin
							if (cnt_q == 7'(i)) begin
								name_d[6*i +: 6] = char_s1[5:0];
							end
						end
						cnt_d = cnt_q + 7'd1;
						if (cnt_d >= 7'(MAX_NAME_CHARS) || cnt_d >= 7'(NAME_SLOTS)) begin
							push.n = 2'd1;
							push.tok0 = TOK_ZERO;
							push.tok0.kind = TK_NAME;
							push.tok0.letters = name_d;
							push.tok0.len = cnt_d[3:0];
							mode_d = MODE_IDLE;
						end
					end else begin
						push.n = fr_emit ? 2'd2 : 2'd1;
						push.tok0 = name_tok;
						push.tok1 = fr_tok;
						mode_d = fr_mode;
					end
				end
				default: begin
					push.n = fr_emit ? 2'd1 : 2'd0;
					push.tok0 = fr_tok;
					mode_d = fr_mode;
				end
			endcase

			// A fresh digit or letter opens a new token.
			if (mode_q != MODE_HALT && (fr_num || fr_name) &&
				!(mode_q == MODE_NUMBER && (is_digit || char_s1 == CH_DOT)) &&
				!(mode_q == MODE_NAME && is_lower && cnt_q < 7'(NAME_SLOTS))) begin
				cnt_d = 7'd1;
				if (fr_num) begin
					acc_d  = {56'd0, digit};
					frac_d = '0;
					pts_d  = '0;
					sat_d  = 1'b0;
				end else begin
					name_d = {54'd0, char_s1[5:0]};
				end
			end

			push.tok0.last = (push.n == 2'd1);
			push.tok1.last = 1'b1;
		end
	end

	always_comb begin
		num_tok = TOK_ZERO;
		num_tok.kind = TK_NUMBER;
		num_tok.mantissa = acc_q;
		num_tok.frac = frac_q;
		num_tok.ovf = sat_q;
		name_tok = TOK_ZERO;
		name_tok.kind = TK_NAME;
		name_tok.letters = name_q;
		name_tok.len = cnt_q[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
		end else begin
			mode_q <= mode_d;
		end
	end

	// Token contents are only read in number or name mode, which always
	// load them first, so they need no reset.
	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		frac_q <= frac_d;
		pts_q  <= pts_d;
		sat_q  <= sat_d;
		cnt_q  <= cnt_d;
		name_q <= name_d;
	end

	`AET_CHECK(a_halt_silent, mode_q == MODE_HALT |-> push.n == 2'd0, "tokens after halt")
	`AET_CHECK(a_pair_opens_with_operand, push.n == 2'd2 |-> (push.tok0.kind == TK_NUMBER || push.tok0.kind == TK_NAME), "second token without closing a number or name")
	`AET_CHECK(a_invalid_halts, (push.n == 2'd1 && push.tok0.kind == TK_INVALID) || (push.n == 2'd2 && push.tok1.kind == TK_INVALID) |=> mode_q == MODE_HALT, "invalid character did not halt the scanner")

endmodule

`default_nettype wire

[hw/rtl/arithmetic_expression_tokenizer_unit.sv]
// Arithmetic expression tokenizer, top level.
// Instantiates aet_scan and aet_fifo; depends on aet_pkg.
//
// Usage:
//   Input channel: one character word (char_code) per in_valid/in_ready
//   handshake. Output channel: one token word per out_valid/out_ready
//   handshake, with all token fields as separate ports.
//   A character is registered on acceptance and scanned in the next cycle;
//   the tokens it causes are written to an eight-entry queue and offered on
//   the output from the queue, behind any tokens already held there.
//   One character is accepted every cycle while in_ready is high. A
//   character gives zero, one or two tokens; the output moves one token per
//   cycle while out_ready is high, so a character that closes a number or
//   name and is itself a token needs two output handshakes.
//   in_ready drops when the queue, counting the tokens of the character
//   still in the input register, has fewer than four free entries. A
//   stalled receiver therefore backs up into the input without loss.
//   Reset empties the queue and the input register and returns the scanner
//   to idle; in_ready is high as soon as reset is released. After an
//   invalid character the block keeps accepting characters but gives no
//   tokens until the next reset.
`default_nettype none

module arithmetic_expression_tokenizer_unit #(
	parameter int MAX_NUMBER_CHARS = 100,
	parameter int MAX_NAME_CHARS   = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [3:0]       token_kind,
	output logic [59:0]      mantissa,
	output logic [4:0]       fraction_digits,
	output logic             number_overflow,
	output logic [59:0]      name_letters,
	output logic [3:0]       name_length,
	output logic             last_of_run
);
	import aet_pkg::*;

	logic             valid_s1;
	logic [7:0]       char_s1;
	push_t            push;
	tok_t             head;
	logic [CNT_W-1:0] count;

	// Room for the pending character and the next one, two tokens each.
	assign in_ready = ({1'b0, count} + (valid_s1 ? (CNT_W+1)'(2) : '0))
		<= (CNT_W+1)'(QUEUE_DEPTH - 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid && in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
		end
	end

	aet_scan #(
		.MAX_NUMBER_CHARS (MAX_NUMBER_CHARS),
		.MAX_NAME_CHARS   (MAX_NAME_CHARS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1),
		.push     (push)
	);

	aet_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.head      (head),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.count     (count)
	);

	assign token_kind      = head.kind;
	assign mantissa        = head.mantissa;
	assign fraction_digits = head.frac;
	assign number_overflow = head.ovf;
	assign name_letters    = head.letters;
	assign name_length     = head.len;
	assign last_of_run     = head.last;

endmodule

`default_nettype wire
